// ===== src/ipd_pkg.sv =====
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared widths, register indexes, event codes and the command map for the
// pulse-distance infrared frame decoder.
// ----------------------------------------------------------------------------
package ipd_pkg;

    localparam int US_W       = 16;
    localparam int EVT_W      = 2;
    localparam int FRAME_W    = 32;
    localparam int CNT_W      = 6;
    localparam int POS_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0] FRAME_LEN = CNT_W'(FRAME_W);

    typedef logic [US_W-1:0]  t_us;
    typedef logic [EVT_W-1:0] t_evt;

    localparam t_evt EVT_NONE  = 2'd0;
    localparam t_evt EVT_START = 2'd1;
    localparam t_evt EVT_STOP  = 2'd2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX   = 3'd5;

    localparam t_us RST_LEADER_MIN = 16'd12500;
    localparam t_us RST_LEADER_MAX = 16'd14500;
    localparam t_us RST_ONE_MIN    = 16'd1750;
    localparam t_us RST_ONE_MAX    = 16'd2800;
    localparam t_us RST_ZERO_MIN   = 16'd800;
    localparam t_us RST_ZERO_MAX   = 16'd1500;

    localparam logic [7:0] CMD_START_A = 8'h10;
    localparam logic [7:0] CMD_START_B = 8'h11;
    localparam logic [7:0] CMD_STOP_A  = 8'h0D;
    localparam logic [7:0] CMD_STOP_B  = 8'h12;
    localparam logic [7:0] BYTE_ONES   = 8'hFF;

    // address/command complement check, then command to event
    function automatic t_evt ipd_map_event(input logic [FRAME_W-1:0] word);
        logic [7:0] addr;
        logic [7:0] addr_inv;
        logic [7:0] cmd;
        logic [7:0] cmd_inv;
        t_evt       evt;
        addr     = word[7:0];
        addr_inv = word[15:8];
        cmd      = word[23:16];
        cmd_inv  = word[31:24];
        evt      = EVT_NONE;
        if (((addr ^ addr_inv) == BYTE_ONES) && ((cmd ^ cmd_inv) == BYTE_ONES)) begin
            if (cmd == CMD_START_A || cmd == CMD_START_B) begin
                evt = EVT_START;
            end else if (cmd == CMD_STOP_A || cmd == CMD_STOP_B) begin
                evt = EVT_STOP;
            end
        end
        return evt;
    endfunction

endpackage

// ===== src/ipd_in_if.sv =====
// ----------------------------------------------------------------------------
// ipd_in_if
// Interval channel: valid/ready handshake carrying one edge interval a beat.
// ----------------------------------------------------------------------------
interface ipd_in_if
    import ipd_pkg::*;
;
    logic valid;
    logic ready;
    t_us  gap_us;

    modport source (output valid, output gap_us, input ready);
    modport sink   (input valid, input gap_us, output ready);
endinterface

// ===== src/ipd_out_if.sv =====
// ----------------------------------------------------------------------------
// ipd_out_if
// Event channel: valid/ready handshake carrying one event code a beat.
// ----------------------------------------------------------------------------
interface ipd_out_if
    import ipd_pkg::*;
;
    logic valid;
    logic ready;
    t_evt event_res;

    modport source (output valid, output event_res, input ready);
    modport sink   (input valid, input event_res, output ready);
endinterface

// ===== src/ir_pulse_distance_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder
// Decodes NEC-style pulse-distance frames from edge intervals into events.
// ----------------------------------------------------------------------------
// Each input beat is one edge interval in microseconds; each one gives exactly
// one event beat (none, start or stop). The decoder takes one interval per
// clock: window compares, the bit shift and the frame check are combinational
// ahead of the output register, so the event appears the cycle after the
// interval is taken, and a new interval is taken in the same cycle as the
// held event drains; only a stalled output holds off the input. The user writes
// the six window limits on the configuration port only while idle, unenforced.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder
    import ipd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ipd_in_if.sink                i_item,
    ipd_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_us r_leader_min, r_leader_max;
    t_us r_one_min, r_one_max;
    t_us r_zero_min, r_zero_max;

    logic [FRAME_W-1:0] r_bits, n_bits;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_in_frame, n_in_frame;
    t_evt               r_evt, n_evt;
    logic               r_out_valid;

    logic accept;
    logic hit_leader, hit_one, hit_zero;
    t_us  iv;
    logic [CNT_W-1:0] count_inc;

    assign iv           = i_item.gap_us;
    assign i_item.ready = !r_out_valid || o_res.ready;
    assign accept       = i_item.valid && i_item.ready;

    assign hit_leader = (iv >= r_leader_min) && (iv <= r_leader_max);
    assign hit_one    = (iv >= r_one_min) && (iv <= r_one_max);
    assign hit_zero   = (iv >= r_zero_min) && (iv <= r_zero_max);
    assign count_inc  = r_count + CNT_W'(1);

    always_comb begin
        n_bits     = r_bits;
        n_count    = r_count;
        n_in_frame = r_in_frame;
        n_evt      = EVT_NONE;
        if (hit_leader) begin
            n_bits     = '0;
            n_count    = '0;
            n_in_frame = 1'b1;
        end else if (r_in_frame) begin
            if (hit_one || hit_zero) begin
                if (hit_one) begin
                    n_bits = r_bits | (FRAME_W'(1) << r_count[POS_W-1:0]);
                end
                n_count = count_inc;
                if (count_inc >= FRAME_LEN) begin
                    n_in_frame = 1'b0;
                    n_evt      = ipd_map_event(n_bits);
                end
            end else begin
                // anything else, repeat gap included, drops the frame
                n_in_frame = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader_min <= RST_LEADER_MIN;
            r_leader_max <= RST_LEADER_MAX;
            r_one_min    <= RST_ONE_MIN;
            r_one_max    <= RST_ONE_MAX;
            r_zero_min   <= RST_ZERO_MIN;
            r_zero_max   <= RST_ZERO_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEADER_MIN: r_leader_min <= i_cfg_wdata;
                CFG_LEADER_MAX: r_leader_max <= i_cfg_wdata;
                CFG_ONE_MIN:    r_one_min    <= i_cfg_wdata;
                CFG_ONE_MAX:    r_one_max    <= i_cfg_wdata;
                CFG_ZERO_MIN:   r_zero_min   <= i_cfg_wdata;
                CFG_ZERO_MAX:   r_zero_max   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits      <= '0;
            r_count     <= '0;
            r_in_frame  <= 1'b0;
            r_out_valid <= 1'b0;
            r_evt       <= EVT_NONE;
        end else if (accept) begin
            r_bits      <= n_bits;
            r_count     <= n_count;
            r_in_frame  <= n_in_frame;
            r_evt       <= n_evt;
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.event_res = r_evt;

endmodule

// ===== src/ipd_chk.sv =====
// ----------------------------------------------------------------------------
// ipd_chk
// Port-level checks for the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ipd_chk
    import ipd_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_evt i_event_res
);

    // every accepted interval yields an event beat on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted interval gave no event beat");

    // an empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output stage");

    // only the three defined event codes leave the block
    a_evt_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_event_res == EVT_NONE || i_event_res == EVT_START ||
                         i_event_res == EVT_STOP))
        else $error("undefined event code");

    // a stalled event beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_event_res)))
        else $error("stalled event beat changed");

endmodule

bind ir_pulse_distance_frame_decoder ipd_chk u_ipd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_event_res (o_res.event_res)
);

// ===== sim/ipd_event_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipd_event_checker
// Watches the interval and event channels and the configuration port of the
// frame decoder, predicts one event per accepted interval with its own copy
// of the windows and frame state, and compares each event beat in order.
// ----------------------------------------------------------------------------
module ipd_event_checker
    import ipd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ipd_in_if                     i_item_mon,
    ipd_out_if                    i_res_mon,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_starts,
    output int                    o_stops
);

    t_us lead_lo, lead_hi, one_lo, one_hi, zero_lo, zero_hi;

    logic [FRAME_W-1:0] shift_word;
    logic [CNT_W-1:0]   bits_in;
    logic               receiving;

    t_evt event_q[$];
    int   fails;
    int   checked;
    int   starts;
    int   stops;

    function automatic bit in_range(t_us v, t_us lo, t_us hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // complement check on both byte pairs, then command lookup
    function automatic t_evt frame_event(logic [FRAME_W-1:0] w);
        logic [7:0] a, a_n, c, c_n;
        {c_n, c, a_n, a} = w;
        if (a_n != ~a || c_n != ~c) begin
            return EVT_NONE;
        end
        case (c)
            CMD_START_A, CMD_START_B: return EVT_START;
            CMD_STOP_A, CMD_STOP_B:   return EVT_STOP;
            default:                  return EVT_NONE;
        endcase
    endfunction

    // advances the frame state by one interval, returns the event it gives
    function automatic t_evt decode_interval(t_us iv);
        t_evt evt;
        evt = EVT_NONE;
        if (in_range(iv, lead_lo, lead_hi)) begin
            shift_word = '0;
            bits_in    = '0;
            receiving  = 1'b1;
        end else if (receiving) begin
            if (in_range(iv, one_lo, one_hi) || in_range(iv, zero_lo, zero_hi)) begin
                if (in_range(iv, one_lo, one_hi)) begin
                    shift_word[bits_in[POS_W-1:0]] = 1'b1;
                end
                bits_in = bits_in + 1'b1;
                if (bits_in >= FRAME_LEN) begin
                    receiving = 1'b0;
                    evt       = frame_event(shift_word);
                end
            end else begin
                receiving = 1'b0;
            end
        end
        return evt;
    endfunction

    always @(posedge i_clk) begin : watch
        t_evt want;
        if (!i_rst_n) begin
            lead_lo    = RST_LEADER_MIN;
            lead_hi    = RST_LEADER_MAX;
            one_lo     = RST_ONE_MIN;
            one_hi     = RST_ONE_MAX;
            zero_lo    = RST_ZERO_MIN;
            zero_hi    = RST_ZERO_MAX;
            shift_word = '0;
            bits_in    = '0;
            receiving  = 1'b0;
            event_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEADER_MIN: lead_lo = i_cfg_wdata;
                    CFG_LEADER_MAX: lead_hi = i_cfg_wdata;
                    CFG_ONE_MIN:    one_lo  = i_cfg_wdata;
                    CFG_ONE_MAX:    one_hi  = i_cfg_wdata;
                    CFG_ZERO_MIN:   zero_lo = i_cfg_wdata;
                    CFG_ZERO_MAX:   zero_hi = i_cfg_wdata;
                    default: ;
                endcase
            end
            // event beat first: it belongs to an interval taken at an earlier edge
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (event_q.size() == 0) begin
                    if (fails < 20) begin
                        $display("%0t: event beat %0d with nothing expected",
                                 $time, i_res_mon.event_res);
                    end
                    fails++;
                end else begin
                    want = event_q.pop_front();
                    checked++;
                    if (i_res_mon.event_res !== want) begin
                        if (fails < 20) begin
                            $display("%0t: event_res expected %0d, actual %0d",
                                     $time, want, i_res_mon.event_res);
                        end
                        fails++;
                    end else if (want == EVT_START) begin
                        starts++;
                    end else if (want == EVT_STOP) begin
                        stops++;
                    end
                end
            end
            if (i_item_mon.valid && i_item_mon.ready) begin
                event_q.push_back(decode_interval(i_item_mon.gap_us));
            end
        end
        o_pending    <= event_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_starts     <= starts;
        o_stops      <= stops;
    end

    initial begin
        fails        = 0;
        checked      = 0;
        starts       = 0;
        stops        = 0;
        o_pending    = 0;
        o_fail_count = 0;
        o_checked    = 0;
        o_starts     = 0;
        o_stops      = 0;
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives edge intervals into the frame decoder: a few directed boundary
// cases, then random NEC-style frames, broken frames and noise under a set
// of window settings, with random gaps on both channels. The checker beside
// the decoder predicts and compares every event beat.
// ----------------------------------------------------------------------------
module testbench;
    import ipd_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    int fail_count;
    int pending;
    int checked;
    int starts;
    int stops;

    ipd_in_if  item_ch ();
    ipd_out_if res_ch ();

    ir_pulse_distance_frame_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    ipd_event_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_mon   (item_ch),
        .i_res_mon    (res_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_starts     (starts),
        .o_stops      (stops)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // mirror of the windows, used to aim the stimulus
    t_us lead_lo = RST_LEADER_MIN;
    t_us lead_hi = RST_LEADER_MAX;
    t_us one_lo  = RST_ONE_MIN;
    t_us one_hi  = RST_ONE_MAX;
    t_us zero_lo = RST_ZERO_MIN;
    t_us zero_hi = RST_ZERO_MAX;

    bit calm_in;
    int sent_beats;
    int noise_beats;
    int settings;

    function automatic int gap_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic bit in_range(t_us v, t_us lo, t_us hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // value inside a window, edges favored; anything for an empty window
    function automatic t_us pick_in(t_us lo, t_us hi);
        int r;
        r = $urandom_range(0, 9);
        if (lo > hi) return t_us'($urandom);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return t_us'($urandom_range(hi, lo));
    endfunction

    // value outside every window, mostly just past a window edge
    function automatic t_us pick_stray();
        t_us v;
        v = '0;
        for (int n = 0; n < 16; n++) begin
            case ($urandom_range(0, 4))
                0:       v = lead_lo - 1'b1;
                1:       v = lead_hi + 1'b1;
                2:       v = one_hi + 1'b1;
                3:       v = zero_lo - 1'b1;
                default: v = t_us'($urandom);
            endcase
            if (!in_range(v, lead_lo, lead_hi) && !in_range(v, one_lo, one_hi) &&
                !in_range(v, zero_lo, zero_hi)) begin
                return v;
            end
        end
        return v;
    endfunction

    function automatic logic [FRAME_W-1:0] make_word();
        logic [7:0]         a, c;
        logic [FRAME_W-1:0] w;
        int                 r;
        a = 8'($urandom);
        case ($urandom_range(0, 5))
            0:       c = CMD_START_A;
            1:       c = CMD_START_B;
            2:       c = CMD_STOP_A;
            3:       c = CMD_STOP_B;
            default: c = 8'($urandom);
        endcase
        w = {~c, c, ~a, a};
        r = $urandom_range(0, 99);
        if (r < 15) begin
            w[$urandom_range(0, FRAME_W - 1)] ^= 1'b1;
        end else if (r < 30) begin
            w = $urandom;
        end
        return w;
    endfunction

    task automatic send_us(t_us v);
        if (!calm_in && $urandom_range(0, 99) < 30) begin
            item_ch.valid = 1'b0;
            repeat (gap_len()) @(negedge i_clk);
        end
        item_ch.valid  = 1'b1;
        item_ch.gap_us = v;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
        sent_beats++;
    endtask

    task automatic send_bits(logic [FRAME_W-1:0] word, int count);
        for (int k = 0; k < count; k++) begin
            send_us(word[k] ? pick_in(one_lo, one_hi) : pick_in(zero_lo, zero_hi));
        end
    endtask

    // every interval gives an event, so an empty queue means the decoder is idle
    task automatic drain();
        item_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, t_us val);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
    endtask

    task automatic set_windows(int l0, int l1, int o0, int o1, int z0, int z1);
        drain();
        lead_lo = t_us'(l0);
        lead_hi = t_us'(l1);
        one_lo  = t_us'(o0);
        one_hi  = t_us'(o1);
        zero_lo = t_us'(z0);
        zero_hi = t_us'(z1);
        write_reg(CFG_LEADER_MIN, lead_lo);
        write_reg(CFG_LEADER_MAX, lead_hi);
        write_reg(CFG_ONE_MIN, one_lo);
        write_reg(CFG_ONE_MAX, one_hi);
        write_reg(CFG_ZERO_MIN, zero_lo);
        write_reg(CFG_ZERO_MAX, zero_hi);
        i_cfg_we = 1'b0;
        settings++;
    endtask

    // frames with random content: mostly complete, some aborted or restarted
    task automatic run_frames(int budget);
        int start_beats;
        int r;
        start_beats = sent_beats - noise_beats;
        while (sent_beats - noise_beats - start_beats < budget) begin
            calm_in = ($urandom_range(0, 99) < 25);
            repeat ($urandom_range(0, 2)) begin
                case ($urandom_range(0, 3))
                    0:       send_us('0);
                    1:       send_us('1);
                    default: send_us(t_us'($urandom));
                endcase
                noise_beats++;
            end
            send_us(pick_in(lead_lo, lead_hi));
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_bits(make_word(), FRAME_W);
            end else if (r < 85) begin
                send_bits(make_word(), $urandom_range(0, FRAME_W - 1));
                send_us(pick_stray());
            end else begin
                send_bits(make_word(), $urandom_range(0, FRAME_W - 1));
                send_us(pick_in(lead_lo, lead_hi));
                send_bits(make_word(), FRAME_W);
            end
        end
    endtask

    initial begin : result_sink
        int hold;
        int calm;
        hold         = 0;
        calm         = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                res_ch.ready = 1'b0;
                hold--;
            end else begin
                res_ch.ready = 1'b1;
                if (calm > 0) begin
                    calm--;
                end else if ($urandom_range(0, 99) < 3) begin
                    calm = $urandom_range(20, 80);
                end else if ($urandom_range(0, 99) < 30) begin
                    hold = gap_len();
                end
            end
        end
    end

    initial begin : stimulus
        int z0, z1, o0, o1, l0;
        item_ch.valid  = 1'b0;
        item_ch.gap_us = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_LEADER_MIN;
        i_cfg_wdata    = '0;
        i_rst_n        = 1'b0;
        calm_in        = 1'b0;
        sent_beats     = 0;
        noise_beats    = 0;
        settings       = 1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // idle: extremes and just outside the leader window are ignored
        send_us('0);
        send_us('1);
        send_us(RST_LEADER_MIN - 1'b1);
        send_us(RST_LEADER_MAX + 1'b1);
        // window edges for one and zero bits, then a gap between windows
        send_us(RST_LEADER_MIN);
        send_us(RST_ONE_MAX);
        send_us(RST_ONE_MIN);
        send_us(RST_ZERO_MIN);
        send_us(RST_ZERO_MAX);
        send_us(RST_ZERO_MAX + 1'b1);
        // repeat-frame gap aborts an open frame
        send_us(RST_LEADER_MAX);
        send_us(16'd1000);
        send_us(16'd2000);
        send_us(16'd11250);
        send_us(16'd2250);
        // leader inside a frame restarts it; short pulse then aborts
        send_us(16'd13500);
        send_us(16'd2250);
        send_us(16'd13000);
        send_us(16'd560);
        send_us(16'd1125);

        run_frames(450);
        // single-value windows
        set_windows(9000, 9000, 1690, 1690, 560, 560);
        run_frames(250);
        // field extremes as bit windows
        set_windows(30000, 45000, 65535, 65535, 0, 0);
        run_frames(250);
        // overlapping windows: leader beats one beats zero
        set_windows(2000, 3000, 1500, 2500, 0, 1800);
        run_frames(250);
        // empty zero window
        set_windows(RST_LEADER_MIN, RST_LEADER_MAX, RST_ONE_MIN, RST_ONE_MAX, 5000, 4000);
        run_frames(120);
        // empty leader window: nothing ever starts
        set_windows(65535, 0, RST_ONE_MIN, RST_ONE_MAX, RST_ZERO_MIN, RST_ZERO_MAX);
        run_frames(40);
        // full-range leader window: every interval is a leader
        set_windows(0, 65535, RST_ONE_MIN, RST_ONE_MAX, RST_ZERO_MIN, RST_ZERO_MAX);
        run_frames(40);
        repeat (2) begin
            z0 = $urandom_range(0, 3000);
            z1 = z0 + $urandom_range(0, 2000);
            o0 = z1 + 1 + $urandom_range(0, 1000);
            o1 = o0 + $urandom_range(0, 3000);
            l0 = o1 + 1 + $urandom_range(0, 5000);
            set_windows(l0, l0 + $urandom_range(0, 20000), o0, o1, z0, z1);
            run_frames(125);
        end
        set_windows(RST_LEADER_MIN, RST_LEADER_MAX, RST_ONE_MIN, RST_ONE_MAX,
                    RST_ZERO_MIN, RST_ZERO_MAX);
        run_frames(200);

        drain();
        repeat (8) @(negedge i_clk);
        $display("Sent %0d interval beats (%0d noise) across %0d window settings.",
                 sent_beats, noise_beats, settings);
        $display("Checked %0d event beats: %0d start, %0d stop.", checked, starts, stops);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #1500000;
        $display("Timed out with %0d events outstanding", pending);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ipd_pkg.sv
src/ipd_in_if.sv
src/ipd_out_if.sv
src/ir_pulse_distance_frame_decoder.sv
src/ipd_chk.sv
sim/ipd_event_checker.sv
sim/testbench.sv
